// File: rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants for the 3x3 binary erode/dilate block
// Holds sizes, register indexes, the queue entry format and window helpers.
// ----------------------------------------------------------------------------
package bed_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PIX_W      = 8;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MODE         = 2'd2;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [FW_W-1:0] FW_MAX           = FW_W'(MAX_WIDTH);
	localparam logic [FH_W-1:0] FH_MAX           = FH_W'(MAX_HEIGHT);

	localparam logic MODE_ERODE  = 1'b0;
	localparam logic MODE_DILATE = 1'b1;

	localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

	// Result slots of one input, in emission order
	localparam logic [1:0] EMIT_UP_LEFT   = 2'd0;
	localparam logic [1:0] EMIT_UP_RIGHT  = 2'd1;
	localparam logic [1:0] EMIT_BOT_LEFT  = 2'd2;
	localparam logic [1:0] EMIT_BOT_RIGHT = 2'd3;

	localparam int QDEPTH = 4;
	localparam int Q_AW   = $clog2(QDEPTH);
	localparam int Q_CW   = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [FW_W-1:0] width;   // clamped to 1..MAX_WIDTH
		logic [FH_W-1:0] height;  // clamped to 1..MAX_HEIGHT
		logic            mode;
	} cfg_t;

	typedef struct packed {
		logic [8:0]       win;    // left column [8:6], centre [5:3], right [2:0]
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [3:0]       emits;  // one bit per result slot
	} entry_t;

	// Rows of one window column; the bottom output row uses middle, bottom, bottom
	function automatic logic [2:0] pick_rows(input logic [2:0] col3, input logic bottom);
		logic [2:0] res;
		res = bottom ? {col3[2], col3[2], col3[1]} : col3;
		return res;
	endfunction

	function automatic logic window_hit(input logic [8:0] nine, input logic mode);
		logic res;
		res = (mode == MODE_DILATE) ? (|nine) : (&nine);
		return res;
	endfunction

endpackage

// File: rtl/bed_front.sv
// ----------------------------------------------------------------------------
// bed_front: pixel intake, line flag memory and window shift
// Turns each pixel into a flag, builds the 3x3 window and, if results are due, queues a job entry.
// ----------------------------------------------------------------------------
module bed_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bed_pkg::cfg_t               cfg,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bed_pkg::PIX_W-1:0]   s_tdata,
	output logic                        push,
	output bed_pkg::entry_t             push_data,
	input  logic                        full
);

	logic [1:0] line_mem [bed_pkg::MAX_WIDTH];

	logic [bed_pkg::ROW_W-1:0] row_q;
	logic [bed_pkg::COL_W-1:0] col_q;
	logic [8:0]                win_q;

	logic                      valid_s1;
	logic                      flag_s1;
	logic [1:0]                rd_s1;     // [1] older line, [0] newer line
	logic [bed_pkg::ROW_W-1:0] row_s1;
	logic [bed_pkg::COL_W-1:0] col_s1;
	logic                      last_col_s1;
	logic                      last_row_s1;

	logic                      accept;
	logic                      adv;
	logic                      flag_in;
	logic                      last_col;
	logic                      last_row;
	logic                      mid;
	logic                      top;
	logic [2:0]                vcol;
	logic [8:0]                win_next;
	logic [3:0]                emits;
	logic                      bypass;

	assign accept   = s_tvalid && s_tready;
	assign flag_in  = (cfg.mode == bed_pkg::MODE_DILATE) ? (s_tdata != bed_pkg::PIX_OFF)
	                                                     : (s_tdata == bed_pkg::PIX_ON);
	assign last_col = ({1'b0, col_q} + bed_pkg::FW_W'(1)) >= cfg.width;
	assign last_row = ({1'b0, row_q} + bed_pkg::FH_W'(1)) >= cfg.height;

	always_comb begin
		mid      = (row_s1 >= bed_pkg::ROW_W'(1)) ? rd_s1[0] : flag_s1;
		top      = (row_s1 >= bed_pkg::ROW_W'(2)) ? rd_s1[1] : mid;
		vcol     = {flag_s1, mid, top};
		win_next = (col_s1 == '0) ? {vcol, vcol, vcol} : {win_q[5:0], vcol};
		emits[bed_pkg::EMIT_UP_LEFT]   = (row_s1 != '0) && (col_s1 != '0);
		emits[bed_pkg::EMIT_UP_RIGHT]  = (row_s1 != '0) && last_col_s1;
		emits[bed_pkg::EMIT_BOT_LEFT]  = last_row_s1 && (col_s1 != '0);
		emits[bed_pkg::EMIT_BOT_RIGHT] = last_row_s1 && last_col_s1;
	end

	// Advance when there is nothing to queue or the queue has room
	assign adv      = valid_s1 && ((emits == '0) || !full);
	assign push     = adv && (emits != '0);
	assign s_tready = !valid_s1 || adv;
	assign bypass   = adv && (col_s1 == col_q);

	assign push_data.win   = win_next;
	assign push_data.row   = row_s1;
	assign push_data.col   = col_s1;
	assign push_data.emits = emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			win_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (adv)
				win_q <= win_next;
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + bed_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + bed_pkg::COL_W'(1);
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flag_s1     <= flag_in;
			row_s1      <= row_q;
			col_s1      <= col_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			rd_s1       <= bypass ? {rd_s1[0], flag_s1} : line_mem[col_q];
		end
	end

	// Shift the column: newer line moves to older, the new flag becomes newer
	always_ff @(posedge clk) begin
		if (adv)
			line_mem[col_s1] <= {rd_s1[0], flag_s1};
	end

endmodule

// File: rtl/bed_fifo.sv
// ----------------------------------------------------------------------------
// bed_fifo: short job queue between the front and back parts
// ----------------------------------------------------------------------------
module bed_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bed_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output bed_pkg::entry_t pop_data,
	output logic            empty
);

	bed_pkg::entry_t          slot_q [bed_pkg::QDEPTH];
	logic [bed_pkg::Q_AW-1:0] wr_q;
	logic [bed_pkg::Q_AW-1:0] rd_q;
	logic [bed_pkg::Q_CW-1:0] cnt_q;

	assign full     = (cnt_q == bed_pkg::Q_CW'(bed_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + bed_pkg::Q_AW'(1);
			if (pop)
				rd_q <= rd_q + bed_pkg::Q_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + bed_pkg::Q_CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - bed_pkg::Q_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_data;
	end

endmodule

// File: rtl/bed_back.sv
// ----------------------------------------------------------------------------
// bed_back: result expansion
// Walks the pending result slots of one job and fills the output register.
// ----------------------------------------------------------------------------
module bed_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mode,
	input  bed_pkg::entry_t pop_data,
	input  logic            empty,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata,
	output logic            m_tlast,
	output logic            m_tuser
);

	bed_pkg::entry_t           cur_q;
	logic [3:0]                pend_q;
	logic                      m_tvalid_q;
	logic [bed_pkg::PIX_W-1:0] pix_q;
	logic [bed_pkg::ROW_W-1:0] orow_q;
	logic [bed_pkg::COL_W-1:0] ocol_q;
	logic                      last_q;
	logic                      eof_q;

	logic [1:0]                sel;
	logic [3:0]                clr;
	logic [3:0]                pend_next;
	logic [2:0]                lc, cc, rc;
	logic                      bottom;
	logic [8:0]                nine;
	logic [bed_pkg::ROW_W-1:0] orow;
	logic [bed_pkg::COL_W-1:0] ocol;
	logic                      emit;
	logic                      out_free;

	always_comb begin
		if (pend_q[bed_pkg::EMIT_UP_LEFT])
			sel = bed_pkg::EMIT_UP_LEFT;
		else if (pend_q[bed_pkg::EMIT_UP_RIGHT])
			sel = bed_pkg::EMIT_UP_RIGHT;
		else if (pend_q[bed_pkg::EMIT_BOT_LEFT])
			sel = bed_pkg::EMIT_BOT_LEFT;
		else
			sel = bed_pkg::EMIT_BOT_RIGHT;
		clr       = 4'b0001 << sel;
		pend_next = pend_q & ~clr;
		// Right-hand slots replicate the right column as the edge
		lc        = sel[0] ? cur_q.win[5:3] : cur_q.win[8:6];
		cc        = sel[0] ? cur_q.win[2:0] : cur_q.win[5:3];
		rc        = cur_q.win[2:0];
		bottom    = sel[1];
		nine      = {bed_pkg::pick_rows(rc, bottom), bed_pkg::pick_rows(cc, bottom),
		             bed_pkg::pick_rows(lc, bottom)};
		orow      = bottom ? cur_q.row : cur_q.row - bed_pkg::ROW_W'(1);
		ocol      = sel[0] ? cur_q.col : cur_q.col - bed_pkg::COL_W'(1);
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = (pend_q != '0) && out_free;
	assign pop      = !empty && ((pend_q == '0) || (emit && (pend_next == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop)
				pend_q <= pop_data.emits;
			else if (emit)
				pend_q <= pend_next;
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= pop_data;
		if (emit) begin
			pix_q  <= bed_pkg::window_hit(nine, mode) ? bed_pkg::PIX_ON : bed_pkg::PIX_OFF;
			orow_q <= orow;
			ocol_q <= ocol;
			last_q <= (pend_next == '0);
			eof_q  <= (sel == bed_pkg::EMIT_BOT_RIGHT);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, ocol_q, orow_q, pix_q};
	assign m_tlast  = last_q;
	assign m_tuser  = eof_q;

endmodule

// File: rtl/binary_erode_dilate_3x3.sv
// ----------------------------------------------------------------------------
// binary_erode_dilate_3x3: 3x3 binary erosion / dilation on a pixel stream
// Throughput: one pixel per cycle while each pixel causes at most one result and
//   m_tready holds; the back part emits one result per cycle unless m_tready is
//   low, and a pixel causing n results (up to 4 at the bottom-right corner) keeps
//   it busy until all n have been emitted.
// Reset: arst_n clears counters, window, queue and handshake state at once;
//   the line flag memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module binary_erode_dilate_3x3 (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [bed_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [bed_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// pixel input
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] pixel
	// result output
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,   // [7:0] out_pixel, [19:8] out_row,
	                                                    // [29:20] out_col, [31:30] zero
	output logic                             m_tlast,   // last_of_run
	output logic                             m_tuser    // [0] end_of_frame
);

	logic [bed_pkg::FW_W-1:0] frame_width_q;
	logic [bed_pkg::FH_W-1:0] frame_height_q;
	logic                     mode_q;

	bed_pkg::cfg_t            cfg;
	bed_pkg::entry_t          push_data;
	bed_pkg::entry_t          pop_data;
	logic                     push;
	logic                     pop;
	logic                     full;
	logic                     empty;

	// Register writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bed_pkg::FRAME_WIDTH_RST;
			frame_height_q <= bed_pkg::FRAME_HEIGHT_RST;
			mode_q         <= bed_pkg::MODE_ERODE;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bed_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[bed_pkg::FW_W-1:0];
				bed_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				bed_pkg::REG_MODE:         mode_q         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Clamp sizes: zero acts as one, oversize saturates at the maximum
	always_comb begin
		if (frame_width_q == '0)
			cfg.width = bed_pkg::FW_W'(1);
		else if (frame_width_q > bed_pkg::FW_MAX)
			cfg.width = bed_pkg::FW_MAX;
		else
			cfg.width = frame_width_q;
		if (frame_height_q == '0)
			cfg.height = bed_pkg::FH_W'(1);
		else if (frame_height_q > bed_pkg::FH_MAX)
			cfg.height = bed_pkg::FH_MAX;
		else
			cfg.height = frame_height_q;
		cfg.mode = mode_q;
	end

	// Front: take pixels, keep line flags, form windows, queue jobs
	bed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Queue: lets the front keep taking pixels while results drain
	bed_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Back: expand each job into its results, one beat per cycle while m_tready allows
	bed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// Frame end always closes the run of its pixel
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end_of_frame beat without last_of_run");

	// Results are binary
	a_binary: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == bed_pkg::PIX_ON) || (m_tdata[7:0] == bed_pkg::PIX_OFF))
		else $error("result pixel not 0 or 255");

	// The frame's final result sits in the last column
	a_eof_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> ({1'b0, m_tdata[29:20]} == cfg.width - bed_pkg::FW_W'(1)))
		else $error("end_of_frame beat off the last column");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for binary_erode_dilate_3x3
// Streams pixel frames into the block, runs a bit-true erode/dilate predictor
// on every accepted pixel beat and compares each result beat, field by field,
// against the oldest pending prediction while both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import bed_pkg::*;

	// No-handshake limit: the long receiver hold plus random stalls and drains
	// stay far below this on a correct run.
	localparam int WATCHDOG_LIMIT = 4000;
	// Pause before a register write so that a pixel beat that produces no
	// result has left the pipeline.
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;

	localparam logic [CFG_DATA_W-1:0] CFG_ERODE  = CFG_DATA_W'(MODE_ERODE);
	localparam logic [CFG_DATA_W-1:0] CFG_DILATE = CFG_DATA_W'(MODE_DILATE);

	// One result beat, as carried on the master side
	typedef struct packed {
		logic [7:0]  pix;
		logic [11:0] row;
		logic [9:0]  col;
		logic        last;
		logic        eof;
	} morph_res_t;

	// Directed rows: a register write, a pixel checked by the predictor, or a
	// pixel of a 1x1 frame whose single result is typed in as want
	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_CHK} dir_kind_t;

	typedef struct packed {
		dir_kind_t               kind;
		logic [CFG_ADDR_W-1:0]   addr;
		logic [CFG_DATA_W-1:0]   val;
		logic [7:0]              pix;
		logic [7:0]              want;
	} dir_row_t;

	localparam int DIR_ROWS = 42;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// 1x1 frames, erode mode left at its reset value
		'{ROW_CFG,     REG_FRAME_WIDTH,  13'd1,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_FRAME_HEIGHT, 13'd1,      PIX_OFF, PIX_OFF},
		'{ROW_PIX_CHK, REG_MODE,         13'd0,      PIX_ON,  PIX_ON},
		'{ROW_PIX_CHK, REG_MODE,         13'd0,      8'd254,  PIX_OFF},
		'{ROW_PIX_CHK, REG_MODE,         13'd0,      PIX_OFF, PIX_OFF},
		// 1x1 frames in dilate mode
		'{ROW_CFG,     REG_MODE,         CFG_DILATE, PIX_OFF, PIX_OFF},
		'{ROW_PIX_CHK, REG_MODE,         13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_PIX_CHK, REG_MODE,         13'd0,      8'd1,    PIX_ON},
		'{ROW_PIX_CHK, REG_MODE,         13'd0,      8'd128,  PIX_ON},
		// zero sizes act as a 1x1 frame
		'{ROW_CFG,     REG_FRAME_WIDTH,  13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_FRAME_HEIGHT, 13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_PIX_CHK, REG_MODE,         13'd0,      PIX_ON,  PIX_ON},
		// 3x3 erode frame with one hole; the corner beat emits four results
		'{ROW_CFG,     REG_FRAME_WIDTH,  13'd3,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_FRAME_HEIGHT, 13'd3,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_MODE,         CFG_ERODE,  PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      8'd254,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		// 2x2 frame, mode flipped mid-frame: stored flags keep dilate meaning
		'{ROW_CFG,     REG_FRAME_WIDTH,  13'd2,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_FRAME_HEIGHT, 13'd2,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_MODE,         CFG_DILATE, PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      8'd7,    PIX_OFF},
		'{ROW_CFG,     REG_MODE,         CFG_ERODE,  PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_ON,  PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      8'd200,  PIX_OFF},
		// width shrinks mid-row: the column past the new edge ends the row
		'{ROW_CFG,     REG_FRAME_WIDTH,  13'd4,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_FRAME_HEIGHT, 13'd2,      PIX_OFF, PIX_OFF},
		'{ROW_CFG,     REG_MODE,         CFG_DILATE, PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      8'd9,    PIX_OFF},
		'{ROW_CFG,     REG_FRAME_WIDTH,  13'd2,      PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      PIX_OFF, PIX_OFF},
		'{ROW_PIX,     REG_MODE,         13'd0,      8'd3,    PIX_OFF}
	};

	// Block inputs, known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic [7:0]            s_tdata   = 8'd0;
	logic                  m_tready  = 1'b0;

	logic                  s_tready;
	logic                  m_tvalid;
	logic [31:0]           m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	// Stall control shared by the stimulus and the receiver
	int snd_idle   = 0;
	int rcv_idle   = 0;
	int hold_ask   = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int idle_ticks = 0;
	int err_cnt    = 0;

	// Predictor state: configuration, line flags, raster position, window
	logic [FW_W-1:0] cfg_width  = FRAME_WIDTH_RST;
	logic [FH_W-1:0] cfg_height = FRAME_HEIGHT_RST;
	logic            cfg_mode   = MODE_ERODE;
	bit              older_flags [MAX_WIDTH];
	bit              newer_flags [MAX_WIDTH];
	logic [11:0]     row_pos    = '0;
	logic [9:0]      col_pos    = '0;
	logic [8:0]      win_flags  = '0;

	morph_res_t      step_results [4];
	morph_res_t      due_results [$];

	binary_erode_dilate_3x3 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #6 clk = ~clk;

	// Build one result from three window columns; on the bottom output row each
	// column uses its middle, bottom, bottom flags (edge replication).
	function automatic morph_res_t make_result(input logic [2:0] lc, input logic [2:0] mc,
			input logic [2:0] rc, input bit bottom, input int row, input int col,
			input bit eof);
		logic [8:0] nine;
		bit         hit;
		morph_res_t res;
		if (bottom) begin
			nine = {lc[2], lc[2], lc[1], mc[2], mc[2], mc[1], rc[2], rc[2], rc[1]};
		end else begin
			nine = {lc, mc, rc};
		end
		hit      = (cfg_mode == MODE_DILATE) ? (nine != 9'd0) : (nine == 9'h1FF);
		res.pix  = hit ? PIX_ON : PIX_OFF;
		res.row  = 12'(row);
		res.col  = 10'(col);
		res.last = 1'b0;
		res.eof  = eof;
		return res;
	endfunction

	// Advance the predictor by one pixel; fill step_results and return the count
	function automatic int erode_dilate_step(input logic [7:0] pix);
		int         w, h, r, c, n;
		bit         f, top, mid, lastc, lastr;
		logic [2:0] v, cl, cm, cr;
		w = int'(cfg_width);
		h = int'(cfg_height);
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		r = int'(row_pos);
		c = int'(col_pos);

		// flag of this pixel; rows above fall back to it at the top edge
		f   = (cfg_mode == MODE_DILATE) ? (pix != PIX_OFF) : (pix == PIX_ON);
		mid = (r >= 1) ? newer_flags[c] : f;
		top = (r >= 2) ? older_flags[c] : mid;
		older_flags[c] = newer_flags[c];
		newer_flags[c] = f;
		v = {f, mid, top};
		win_flags = (c == 0) ? {v, v, v} : {win_flags[5:0], v};

		lastc = (c + 1 >= w);
		lastr = (r + 1 >= h);
		cl = win_flags[8:6];
		cm = win_flags[5:3];
		cr = win_flags[2:0];
		n  = 0;
		if (r >= 1) begin
			if (c >= 1) begin
				step_results[n] = make_result(cl, cm, cr, 1'b0, r - 1, c - 1, 1'b0);
				n++;
			end
			if (lastc) begin
				step_results[n] = make_result(cm, cr, cr, 1'b0, r - 1, c, 1'b0);
				n++;
			end
		end
		if (lastr) begin
			if (c >= 1) begin
				step_results[n] = make_result(cl, cm, cr, 1'b1, r, c - 1, 1'b0);
				n++;
			end
			if (lastc) begin
				step_results[n] = make_result(cm, cr, cr, 1'b1, r, c, 1'b1);
				n++;
			end
		end
		if (n > 0) step_results[n - 1].last = 1'b1;

		if (lastc) begin
			col_pos = '0;
			row_pos = lastr ? 12'd0 : row_pos + 12'd1;
		end else begin
			col_pos = col_pos + 10'd1;
		end
		return n;
	endfunction

	// Pixel mix: a share of full-on pixels set per frame, the rest zero or random
	function automatic logic [7:0] random_pixel(input int on_share);
		if ($urandom_range(0, 9) < on_share) return PIX_ON;
		if ($urandom_range(0, 1) == 0) return PIX_OFF;
		return 8'($urandom);
	endfunction

	// Write one register; the write lands on the next edge, then drop the enable
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int val);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		case (addr)
			REG_FRAME_WIDTH:  cfg_width  = FW_W'(val);
			REG_FRAME_HEIGHT: cfg_height = FH_W'(val);
			REG_MODE:         cfg_mode   = val[0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one pixel beat, with random gaps ahead of it, and queue what it causes.
	// A typed row replaces the predicted single result with the typed pixel.
	task automatic send_pixel(input logic [7:0] pix, input bit typed, input logic [7:0] want);
		int         n;
		morph_res_t res;
		while ($urandom_range(0, 99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n = erode_dilate_step(pix);
		if (typed) begin
			res = '{want, 12'd0, 10'd0, 1'b1, 1'b1};
			due_results.push_back(res);
		end else begin
			for (int i = 0; i < n; i++) due_results.push_back(step_results[i]);
		end
	endtask

	// Stop offering, wait for every pending result, then let the pipeline settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Complete frames of random small sizes, mode and pixel mix until the quota
	task automatic run_frames(input int quota);
		int w, h, on_share, done;
		done = 0;
		while (done < quota) begin
			if ($urandom_range(0, 7) == 0) begin
				w = $urandom_range(7, 40);
				h = $urandom_range(1, 3);
			end else begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 5);
			end
			on_share = $urandom_range(2, 9);
			drain_results();
			write_reg(REG_FRAME_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
			write_reg(REG_MODE, $urandom_range(0, 1));
			repeat (w * h) send_pixel(random_pixel(on_share), 1'b0, PIX_OFF);
			done += w * h;
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			err_cnt++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Receiver: random back-pressure, or a long hold when the stimulus asks for one
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ask != hold_seen) begin
			m_tready  <= 1'b0;
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready  <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	// Result checker: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		morph_res_t seen, want;
		if (m_tvalid && m_tready) begin
			seen = '{m_tdata[7:0], m_tdata[19:8], m_tdata[29:20], m_tlast, m_tuser};
			if (due_results.size() == 0) begin
				err_cnt++;
				$display("%0t ns: unexpected result, expected none, actual pix %0d row %0d col %0d",
					$time, seen.pix, seen.row, seen.col);
			end else begin
				want = due_results.pop_front();
				check_field("out_pixel", want.pix, seen.pix);
				check_field("out_row", want.row, seen.row);
				check_field("out_col", want.col, seen.col);
				check_field("last_of_run", want.last, seen.last);
				check_field("end_of_frame", want.eof, seen.eof);
			end
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_ticks <= 0;
		end else if (idle_ticks >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_ticks <= idle_ticks + 1;
		end
	end

	initial begin
		snd_idle = 6;
		rcv_idle = 84;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table; register writes only once drained
		for (int k = 0; k < DIR_ROWS; k++) begin
			case (DIR_TAB[k].kind)
				ROW_CFG: begin
					drain_results();
					write_reg(DIR_TAB[k].addr, int'(DIR_TAB[k].val));
				end
				ROW_PIX:     send_pixel(DIR_TAB[k].pix, 1'b0, PIX_OFF);
				ROW_PIX_CHK: send_pixel(DIR_TAB[k].pix, 1'b1, DIR_TAB[k].want);
				default: ;
			endcase
		end

		// Random frames: slow receiver, then slow sender, then free running
		run_frames(40);
		snd_idle = 84;
		rcv_idle = 6;
		run_frames(40);
		snd_idle = 0;
		rcv_idle = 0;
		run_frames(30);

		// Hold the receiver off while the sender keeps offering a full frame,
		// so that the queue fills and the input stalls
		drain_results();
		write_reg(REG_FRAME_WIDTH, 8);
		write_reg(REG_FRAME_HEIGHT, 4);
		write_reg(REG_MODE, MODE_DILATE);
		hold_ask++;
		repeat (32) send_pixel(random_pixel(5), 1'b0, PIX_OFF);

		// Oversize width and maximum height, then shrink both mid-frame: the fifth
		// column ends row 0, and a zero height makes row 3 the last row
		drain_results();
		write_reg(REG_FRAME_WIDTH, 2047);
		write_reg(REG_FRAME_HEIGHT, MAX_HEIGHT);
		write_reg(REG_MODE, MODE_DILATE);
		repeat (4) send_pixel(random_pixel(5), 1'b0, PIX_OFF);
		drain_results();
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 8191);
		repeat (5) send_pixel(random_pixel(5), 1'b0, PIX_OFF);
		drain_results();
		write_reg(REG_FRAME_HEIGHT, 0);
		repeat (2) send_pixel(random_pixel(5), 1'b0, PIX_OFF);

		drain_results();
		if (err_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
